[rtl/qpe_pkg.sv]
`timescale 1ns / 1ps
package qpe_pkg;

  localparam int unsigned MaxChars = 5;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_EQ  = 8'd61;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_0   = 8'd48;
  localparam logic [7:0] CH_A   = 8'd65;

  localparam logic [7:0] LIMIT_RESET = 8'd72;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  typedef logic [MaxChars-1:0][7:0] chars_t;

  typedef struct packed {
    chars_t     chars;
    logic [2:0] cnt;
    logic [7:0] col_next;
    logic       blank_next;
  } enc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_0 + {4'd0, nib};
    end else begin
      r = CH_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

[rtl/qpe_encode.sv]
`timescale 1ns / 1ps
module qpe_encode (
  input  qpe_pkg::item_t item,
  input  logic [7:0]     col,
  input  logic           blank,
  input  logic [7:0]     limit,
  output qpe_pkg::enc_t  enc
);

  logic                 esc;
  logic [8:0]           col_new;
  logic                 blank_new;
  logic                 tail;
  logic [2:0]           mcnt;
  qpe_pkg::chars_t      main;

  always_comb begin
    esc = ((item.data_byte < qpe_pkg::CH_SP) && (item.data_byte != qpe_pkg::CH_LF) &&
           (item.data_byte != qpe_pkg::CH_TAB)) ||
          (item.data_byte == qpe_pkg::CH_EQ) || (item.data_byte >= qpe_pkg::CH_DEL);
    main = '0;
    if (esc) begin
      main[0]   = qpe_pkg::CH_EQ;
      main[1]   = qpe_pkg::hex_digit(item.data_byte[7:4]);
      main[2]   = qpe_pkg::hex_digit(item.data_byte[3:0]);
      mcnt      = 3'd3;
      col_new   = {1'b0, col} + 9'd3;
      blank_new = 1'b0;
    end else if (item.data_byte == qpe_pkg::CH_LF) begin
      if (blank) begin
        main[0] = qpe_pkg::CH_EQ;
        main[1] = qpe_pkg::CH_LF;
        main[2] = qpe_pkg::CH_LF;
        mcnt    = 3'd3;
      end else begin
        main[0] = qpe_pkg::CH_LF;
        mcnt    = 3'd1;
      end
      col_new   = '0;
      blank_new = 1'b0;
    end else begin
      main[0]   = item.data_byte;
      mcnt      = 3'd1;
      col_new   = {1'b0, col} + 9'd1;
      blank_new = (item.data_byte == qpe_pkg::CH_SP) || (item.data_byte == qpe_pkg::CH_TAB);
    end

    // soft break on overflow, or closing break at end of message
    tail = (col_new > {1'b0, limit}) || (item.end_of_data && (col_new != 9'd0));

    for (int i = 0; i < qpe_pkg::MaxChars; i++) begin
      if (3'(i) < mcnt) begin
        enc.chars[i] = main[i];
      end else if (3'(i) == mcnt) begin
        enc.chars[i] = qpe_pkg::CH_EQ;
      end else begin
        enc.chars[i] = qpe_pkg::CH_LF;
      end
    end
    enc.cnt = tail ? mcnt + 3'd2 : mcnt;
    if (tail || item.end_of_data) begin
      enc.col_next   = '0;
      enc.blank_next = 1'b0;
    end else begin
      enc.col_next   = col_new[7:0];
      enc.blank_next = blank_new;
    end
  end

endmodule

[rtl/quoted_printable_encoder_top.sv]
`timescale 1ns / 1ps
// Each input item is registered in item_q and then loaded into the run register
// (chars, cnt) before its first output character is valid.
// Throughput: one output character per cycle while result_ready is high; an item
// produces 1 to 5 characters (an escaped byte alone produces 3).
// One item is held in the input register while the previous one drains.
// Synchronous reset: queues empty, column 0, line limit 72.
module quoted_printable_encoder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  qpe_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output qpe_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);

  qpe_pkg::item_t  item_q;
  logic            item_q_valid;
  qpe_pkg::chars_t chars;
  logic [2:0]      cnt;
  logic [2:0]      idx;
  logic            seq_valid;
  logic [7:0]      col;
  logic            blank;
  logic [7:0]      limit;
  qpe_pkg::enc_t   enc;
  logic            at_last;
  logic            load;

  qpe_encode u_enc (
    .item  (item_q),
    .col   (col),
    .blank (blank),
    .limit (limit),
    .enc   (enc)
  );

  assign at_last    = (idx == cnt - 3'd1);
  assign load       = item_q_valid && (!seq_valid || (result_ready && at_last));
  assign item_ready = !item_q_valid || load;

  assign result_valid       = seq_valid;
  assign result.out_byte    = chars[idx];
  assign result.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      seq_valid    <= 1'b0;
      idx          <= '0;
      cnt          <= '0;
      col          <= '0;
      blank        <= 1'b0;
      limit        <= qpe_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (item_valid && item_ready) begin
        item_q_valid <= 1'b1;
        item_q       <= item;
      end else if (load) begin
        item_q_valid <= 1'b0;
      end
      if (load) begin
        seq_valid <= 1'b1;
        chars     <= enc.chars;
        cnt       <= enc.cnt;
        idx       <= '0;
        col       <= enc.col_next;
        blank     <= enc.blank_next;
      end else if (seq_valid && result_ready) begin
        if (at_last) begin
          seq_valid <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> (idx < cnt))
    else $error("character index beyond run length");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> (cnt != 3'd0 && cnt <= 3'd5))
    else $error("run length out of range");

  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    (load && item_q.end_of_data) |=> (col == 8'd0 && !blank))
    else $error("column not cleared at end of message");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (seq_valid && result_ready && at_last && !item_q_valid) |=> !seq_valid)
    else $error("run not retired after final transfer");

  a_hold_run: assert property (@(posedge clk) disable iff (rst)
    (seq_valid && !result_ready) |=> (seq_valid && $stable(idx)))
    else $error("stalled run advanced");
`endif

endmodule
